/* hw/rtl/thinning_subpass_window_macros.svh */
// Assertion macros used by the checker file.
`ifndef THINNING_SUBPASS_WINDOW_MACROS_SVH
`define THINNING_SUBPASS_WINDOW_MACROS_SVH

// Same-cycle implication, off during reset.
`define TSW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, off during reset.
`define TSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/tsw_pkg.sv */
package tsw_pkg;

  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned MODE_W      = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PASS_MODE = 1'b1;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 8'd127;
  localparam logic [MODE_W-1:0]   MODE_FIRST      = 2'd0;
  localparam logic [MODE_W-1:0]   MODE_SECOND     = 2'd1;

  localparam logic [SAMPLE_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [SAMPLE_W-1:0] PIX_WHITE = 8'd255;

  localparam logic [3:0] MIN_BLACKS = 4'd2;
  localparam logic [3:0] MAX_BLACKS = 4'd6;

  // Column bits: [0] above, [1] centre, [2] below; 1 = black.
  typedef logic [2:0] column_t;

  typedef struct packed {
    column_t l;
    column_t c;
    column_t r;
    logic    last;
    logic    done;
  } job_t;

  function automatic logic judge(input column_t l, input column_t c, input column_t r,
                                 input logic [MODE_W-1:0] mode);
    logic [7:0] ring;
    logic [3:0] blacks;
    logic [3:0] trans;
    logic       p2w;
    logic       p4w;
    logic       p6w;
    logic       p8w;
    logic       t1;
    logic       t2;
    logic       ok;
    ring   = {l[0], l[1], l[2], c[2], r[2], r[1], r[0], c[0]};
    blacks = 4'd0;
    trans  = 4'd0;
    for (int k = 0; k < 8; k++) begin
      blacks = blacks + {3'b000, ring[k]};
      trans  = trans + {3'b000, (!ring[k] && ring[(k + 1) % 8])};
    end
    p2w = !ring[0];
    p4w = !ring[2];
    p6w = !ring[4];
    p8w = !ring[6];
    t1  = (p2w || p4w || p6w) && (p4w || p6w || p8w);
    t2  = (p2w || p4w || p8w) && (p2w || p6w || p8w);
    case (mode)
      MODE_FIRST:  ok = t1;
      MODE_SECOND: ok = t2;
      default:     ok = t1 || t2;
    endcase
    return c[1] && (blacks >= MIN_BLACKS) && (blacks <= MAX_BLACKS)
           && (trans == 4'd1) && ok;
  endfunction

endpackage

/* hw/rtl/tsw_if.sv */
interface tsw_in_if
  import tsw_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_above;
  logic [SAMPLE_W-1:0] sample_centre;
  logic [SAMPLE_W-1:0] sample_below;
  logic                row_end;
  logic                frame_end;

  modport source(output valid, sample_above, sample_centre, sample_below, row_end,
                 frame_end, input ready);
  modport sink(input valid, sample_above, sample_centre, sample_below, row_end,
               frame_end, output ready);
endinterface

interface tsw_out_if
  import tsw_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] pixel_out;
  logic                removed;
  logic                row_last;
  logic                frame_done;
  logic                frame_changed;

  modport source(output valid, pixel_out, removed, row_last, frame_done, frame_changed,
                 input ready);
  modport sink(input valid, pixel_out, removed, row_last, frame_done, frame_changed,
               output ready);
endinterface

/* hw/rtl/tsw_window.sv */
module tsw_window
  import tsw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  tsw_in_if.sink              pix_in,
  input  logic [SAMPLE_W-1:0] threshold,
  output job_t                job,
  output logic                job_valid,
  input  logic                job_ready
);

  logic    hold_valid;
  column_t hold_col;
  logic    hold_rend;
  logic    hold_fend;
  logic    phase;
  column_t left;
  column_t centre;
  logic    present;

  logic    need_out;
  logic    step;
  logic    consume;
  logic    accept;
  logic    flush;
  column_t col_next;

  assign col_next = {pix_in.sample_below < threshold,
                     pix_in.sample_centre < threshold,
                     pix_in.sample_above < threshold};

  // Phase 0 emits the waiting centre (or a lone row-end column); phase 1 emits the row-end column.
  assign need_out = phase || present || hold_rend;
  assign flush    = phase || (!present && hold_rend);
  assign job_valid = hold_valid && need_out;
  assign step      = hold_valid && (!need_out || job_ready);
  assign consume   = step && (phase || !present || !hold_rend);
  assign pix_in.ready = !hold_valid || consume;
  assign accept    = pix_in.valid && pix_in.ready;

  always_comb begin
    if (phase) begin
      job = '{l: left, c: centre, r: 3'b000, last: 1'b1, done: hold_fend};
    end else if (present) begin
      job = '{l: left, c: centre, r: hold_col, last: 1'b0, done: 1'b0};
    end else begin
      job = '{l: centre, c: hold_col, r: 3'b000, last: 1'b1, done: hold_fend};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      phase      <= 1'b0;
      left       <= '0;
      centre     <= '0;
      present    <= 1'b0;
    end else begin
      if (accept) begin
        hold_valid <= 1'b1;
      end else if (consume) begin
        hold_valid <= 1'b0;
      end
      if (accept || consume) begin
        phase <= 1'b0;
      end else if (step && present && hold_rend) begin
        phase <= 1'b1;
      end
      if (step) begin
        if (flush) begin
          left    <= '0;
          centre  <= '0;
          present <= 1'b0;
        end else begin
          left    <= centre;
          centre  <= hold_col;
          present <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_col  <= col_next;
      hold_rend <= pix_in.row_end || pix_in.frame_end;
      hold_fend <= pix_in.frame_end;
    end
  end

endmodule

/* hw/rtl/tsw_emit.sv */
module tsw_emit
  import tsw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  job_t              job,
  input  logic              job_valid,
  output logic              job_ready,
  input  logic [MODE_W-1:0] pass_mode,
  tsw_out_if.source         pix_out
);

  logic out_valid;
  logic any_removed;
  logic rem;
  logic load;

  assign rem       = judge(job.l, job.c, job.r, pass_mode);
  assign job_ready = !out_valid || pix_out.ready;
  assign load      = job_valid && job_ready;
  assign pix_out.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      any_removed <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pix_out.ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        if (job.done) begin
          any_removed <= 1'b0;
        end else if (rem) begin
          any_removed <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_out.pixel_out     <= (job.c[1] && !rem) ? PIX_BLACK : PIX_WHITE;
      pix_out.removed       <= rem;
      pix_out.row_last      <= job.last;
      pix_out.frame_done    <= job.done;
      pix_out.frame_changed <= job.done && (any_removed || rem);
    end
  end

endmodule

/* hw/rtl/thinning_subpass_window.sv */
// One Zhang-Suen thinning sub-pass over an image streamed column by column.
// pix_in takes one request per column: three gray samples (above, centre,
// below the centre row; the host supplies white outside the image) plus
// row_end and frame_end. pix_out gives one request per image pixel: the
// thinned pixel (0 or 255), a removed flag, row_last, and on the last pixel
// of the frame frame_done with frame_changed (any removal in the frame).
// Configuration: cfg_we with cfg_index 0 writes threshold, 1 writes
// pass_mode (0 first test, 1 second test, 2 or 3 either). Write only idle.
// The pixel of a column comes out once the next column (its right
// neighbor) arrives; a row-end column also yields its own pixel at once.
// The request that completes a window is held in the input register and its
// result is registered in the output register. A row-end column that follows
// others in its row yields two results over the single output register and
// holds the input register until both are loaded; a single-column row yields one.
// A stalled receiver holds the output register; one more column waits in
// the input register, after which pix_in.ready drops.
// Reset clears the window to white, the frame removal flag, threshold to
// 127 and pass_mode to 0.
module thinning_subpass_window
  import tsw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  tsw_in_if.sink                 pix_in,
  tsw_out_if.source              pix_out,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [SAMPLE_W-1:0] threshold;
  logic [MODE_W-1:0]   pass_mode;
  job_t                job;
  logic                job_valid;
  logic                job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      pass_mode <= MODE_FIRST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold <= cfg_data[SAMPLE_W-1:0];
        CFG_PASS_MODE: pass_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  tsw_window u_window (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in),
    .threshold (threshold),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready)
  );

  tsw_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .pass_mode (pass_mode),
    .pix_out   (pix_out)
  );

endmodule

/* hw/rtl/tsw_checker.sv */
`include "thinning_subpass_window_macros.svh"

module tsw_checker
  import tsw_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] pixel_out,
  input logic                removed,
  input logic                row_last,
  input logic                frame_done,
  input logic                frame_changed
);

  `TSW_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(removed) && $stable(frame_done))
  `TSW_ASSERT_IMPLY(a_changed_on_done, clk, rst, out_valid && frame_changed, frame_done)
  `TSW_ASSERT_IMPLY(a_done_ends_row, clk, rst, out_valid && frame_done, row_last)
  `TSW_ASSERT_IMPLY(a_removed_white, clk, rst, out_valid && removed, pixel_out == PIX_WHITE)

endmodule

bind thinning_subpass_window tsw_checker u_tsw_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (pix_out.valid),
  .out_ready     (pix_out.ready),
  .pixel_out     (pix_out.pixel_out),
  .removed       (pix_out.removed),
  .row_last      (pix_out.row_last),
  .frame_done    (pix_out.frame_done),
  .frame_changed (pix_out.frame_changed)
);
